>>> hw/rtl/vtrp_pkg.sv
// ----------------------------------------------------------------------------
// vtrp_pkg
// Shared types and constants for the terminal reply report parser.
// ----------------------------------------------------------------------------
package vtrp_pkg;

    localparam int VALUE_BITS_DEF = 16;
    localparam int BYTE_W         = 8;
    localparam int ROW_W          = 16;
    localparam int CAPS_W         = 17;
    localparam int M_TDATA_W      = 56;

    localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_LB    = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_Q     = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_DA    = 8'h63;
    localparam logic [BYTE_W-1:0] CH_CPR   = 8'h52;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_ESC  = 5'b00010,
        PH_CSI  = 5'b00100,
        PH_DA   = 5'b01000,
        PH_CPR  = 5'b10000
    } phase_t;

    typedef enum logic [2:0] {
        NUM_SKIP   = 3'b001,
        NUM_DIGITS = 3'b010,
        NUM_DONE   = 3'b100
    } num_phase_t;

    typedef struct packed {
        num_phase_t phase;
        logic       negative;
    } num_state_t;

    typedef struct packed {
        logic                     kind;
        logic [ROW_W-1:0]         row;
        logic [ROW_W-1:0]         col;
        logic signed [CAPS_W-1:0] caps;
    } report_t;

endpackage

>>> hw/rtl/vtrp_num_acc.sv
// ----------------------------------------------------------------------------
// vtrp_num_acc
// One atoi-style step: whitespace skip, sign, saturating decimal accumulate.
// ----------------------------------------------------------------------------
module vtrp_num_acc
    import vtrp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic [BYTE_W-1:0]     rx_byte,
    input  num_state_t            st_in,
    input  logic [VALUE_BITS-1:0] val_in,
    output num_state_t            st_out,
    output logic [VALUE_BITS-1:0] val_out
);

    localparam int PROD_W = VALUE_BITS + 4;
    localparam logic [PROD_W-1:0] SAT = PROD_W'({VALUE_BITS{1'b1}});

    logic              is_digit;
    logic              is_space;
    logic              take;
    logic [PROD_W-1:0] ext;
    logic [PROD_W-1:0] prod;

    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_space = (rx_byte == CH_SP) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
    assign ext      = PROD_W'(val_in);
    assign prod     = (ext << 3) + (ext << 1) + PROD_W'(rx_byte[3:0]);

    always_comb
    begin
        st_out = st_in;
        take   = 1'b0;
        unique case (st_in.phase)
            NUM_SKIP:
            begin
                priority if (is_space)
                begin
                    st_out.phase = NUM_SKIP;
                end
                else if (rx_byte == CH_PLUS)
                begin
                    st_out.phase = NUM_DIGITS;
                end
                else if (rx_byte == CH_MINUS)
                begin
                    st_out.phase    = NUM_DIGITS;
                    st_out.negative = 1'b1;
                end
                else if (!is_digit)
                begin
                    st_out.phase = NUM_DONE;
                end
                else
                begin
                    st_out.phase = NUM_DIGITS;
                    take         = 1'b1;
                end
            end
            NUM_DIGITS:
            begin
                if (is_digit)
                begin
                    take = 1'b1;
                end
                else
                begin
                    st_out.phase = NUM_DONE;
                end
            end
            default:
            begin
                st_out = st_in;
            end
        endcase
    end

    always_comb
    begin
        if (!take)
        begin
            val_out = val_in;
        end
        else if (prod > SAT)
        begin
            val_out = {VALUE_BITS{1'b1}};
        end
        else
        begin
            val_out = prod[VALUE_BITS-1:0];
        end
    end

endmodule

>>> hw/rtl/vtrp_parser.sv
// ----------------------------------------------------------------------------
// vtrp_parser
// Sequence state, field values and report build for one byte per cycle in which in_valid is high.
// ----------------------------------------------------------------------------
module vtrp_parser
    import vtrp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              res_valid,
    output report_t           res
);

    localparam int RW = (VALUE_BITS > ROW_W) ? VALUE_BITS : ROW_W;
    localparam int CW = (VALUE_BITS > CAPS_W) ? VALUE_BITS : CAPS_W;

    phase_t                phase_reg, phase_next;
    logic                  semi_reg, semi_next;
    num_state_t            num_reg, num_next;
    logic [VALUE_BITS-1:0] first_reg, first_next;
    logic [VALUE_BITS-1:0] second_reg, second_next;
    logic                  first_neg_reg, first_neg_next;

    logic                  eff_semi;
    num_state_t            eff_num;
    logic [VALUE_BITS-1:0] eff_first;
    logic [VALUE_BITS-1:0] eff_second;
    logic                  eff_first_neg;
    logic                  cpr_body;
    logic                  hit;
    logic                  cpr_ok;
    num_state_t            acc_st;
    logic [VALUE_BITS-1:0] acc_val_in;
    logic [VALUE_BITS-1:0] acc_val;
    logic [RW-1:0]         first_ext;
    logic [RW-1:0]         second_ext;
    logic [CW-1:0]         caps_ext;
    logic [CAPS_W-1:0]     caps_mag;

    localparam num_state_t NUM_CLEAR = '{phase: NUM_SKIP, negative: 1'b0};

    // entering a body from CSI starts from cleared fields
    always_comb
    begin
        if (phase_reg == PH_CSI)
        begin
            eff_semi      = 1'b0;
            eff_num       = NUM_CLEAR;
            eff_first     = '0;
            eff_second    = '0;
            eff_first_neg = 1'b0;
        end
        else
        begin
            eff_semi      = semi_reg;
            eff_num       = num_reg;
            eff_first     = first_reg;
            eff_second    = second_reg;
            eff_first_neg = first_neg_reg;
        end
    end

    assign acc_val_in = eff_semi ? eff_second : eff_first;

    vtrp_num_acc #(
        .VALUE_BITS (VALUE_BITS)
    ) u_num_acc (
        .rx_byte (rx_byte),
        .st_in   (eff_num),
        .val_in  (acc_val_in),
        .st_out  (acc_st),
        .val_out (acc_val)
    );

    assign first_ext  = RW'(eff_first);
    assign second_ext = RW'(eff_second);
    assign caps_ext   = CW'(eff_second);
    assign caps_mag   = caps_ext[CAPS_W-1:0];
    assign cpr_ok     = eff_semi && !eff_first_neg && (eff_first != '0) &&
                        !eff_num.negative && (eff_second != '0);
    assign cpr_body   = (phase_reg == PH_CPR) || ((phase_reg == PH_CSI) && (rx_byte != CH_Q));

    always_comb
    begin
        phase_next     = phase_reg;
        semi_next      = eff_semi;
        num_next       = eff_num;
        first_next     = eff_first;
        second_next    = eff_second;
        first_neg_next = eff_first_neg;
        hit            = 1'b0;
        res            = '0;

        unique case (phase_reg)
            PH_ESC:
            begin
                if (rx_byte == CH_LB)
                begin
                    phase_next = PH_CSI;
                end
                else if (rx_byte != CH_ESC)
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_CSI:
            begin
                phase_next = (rx_byte == CH_Q) ? PH_DA : PH_CPR;
            end
            PH_DA:
            begin
                if (rx_byte == CH_DA)
                begin
                    hit      = 1'b1;
                    res.kind = 1'b1;
                    if (eff_semi)
                    begin
                        res.caps = eff_num.negative ? (CAPS_W'(0) - caps_mag) : caps_mag;
                    end
                    phase_next     = PH_IDLE;
                    semi_next      = 1'b0;
                    num_next       = NUM_CLEAR;
                    first_next     = '0;
                    second_next    = '0;
                    first_neg_next = 1'b0;
                end
                else if (!eff_semi)
                begin
                    if (rx_byte == CH_SEMI)
                    begin
                        semi_next = 1'b1;
                        num_next  = NUM_CLEAR;
                    end
                end
                else
                begin
                    num_next    = acc_st;
                    second_next = acc_val;
                end
            end
            PH_CPR:
            begin
                phase_next = PH_CPR;
            end
            default:
            begin
                phase_next = (rx_byte == CH_ESC) ? PH_ESC : PH_IDLE;
            end
        endcase

        if (cpr_body)
        begin
            if (rx_byte == CH_CPR)
            begin
                hit            = cpr_ok;
                res.kind       = 1'b0;
                res.row        = first_ext[ROW_W-1:0];
                res.col        = second_ext[ROW_W-1:0];
                res.caps       = '0;
                phase_next     = PH_IDLE;
                semi_next      = 1'b0;
                num_next       = NUM_CLEAR;
                first_next     = '0;
                second_next    = '0;
                first_neg_next = 1'b0;
            end
            else if (!eff_semi)
            begin
                if (rx_byte == CH_SEMI)
                begin
                    semi_next      = 1'b1;
                    first_neg_next = eff_num.negative;
                    num_next       = NUM_CLEAR;
                end
                else
                begin
                    num_next   = acc_st;
                    first_next = acc_val;
                end
            end
            else
            begin
                num_next    = acc_st;
                second_next = acc_val;
            end
        end
    end

    assign res_valid = in_valid && hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            semi_reg      <= 1'b0;
            num_reg       <= NUM_CLEAR;
            first_reg     <= '0;
            second_reg    <= '0;
            first_neg_reg <= 1'b0;
        end
        else if (in_valid)
        begin
            phase_reg     <= phase_next;
            semi_reg      <= semi_next;
            num_reg       <= num_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            first_neg_reg <= first_neg_next;
        end
    end

endmodule

>>> hw/rtl/vt_report_response_parser.sv
// ----------------------------------------------------------------------------
// vt_report_response_parser
// Parses cursor position and device attributes replies from a byte stream.
// Path from input transaction to report: input reg, then result reg.
// Throughput: one byte per cycle while the report side is not stalled.
// Reset: async active low; parser returns to idle, both stages empty.
// ----------------------------------------------------------------------------
module vt_report_response_parser
    import vtrp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [15:0] cursor_row, [31:16] cursor_col,
                                            // [48:32] attr_caps, [55:49] zero
    output logic [0:0]           m_tuser    // [0] report_kind
);

    logic              byte_valid_reg, byte_valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              out_valid_reg, out_valid_next;
    report_t           out_reg;
    logic              out_free;
    logic              fire;
    logic              s_accept;
    logic              res_valid;
    report_t           res;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = byte_valid_reg && out_free;
    assign s_tready = !byte_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    vtrp_parser #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fire),
        .rx_byte   (byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        if (s_accept)
        begin
            byte_valid_next = 1'b1;
        end
        else if (fire)
        begin
            byte_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = res_valid;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            byte_reg <= s_tdata;
        end
        if (fire && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {(M_TDATA_W - 2 * ROW_W - CAPS_W)'(0), out_reg.caps, out_reg.col, out_reg.row};

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while result stage free");

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!fire && !m_tvalid) |=> !m_tvalid)
        else $error("result appeared without a processed byte");

    a_attr_zero_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[31:0] == 32'd0))
        else $error("attribute report carries cursor fields");

    a_cursor_zero_caps: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[48:32] == 17'd0))
        else $error("cursor report carries caps field");

endmodule

>>> tb/tb_vt_report_response_parser.sv
// ----------------------------------------------------------------------------
// tb_vt_report_response_parser
// Self-checking bench for the terminal reply report parser. Byte streams of
// cursor position and device attributes replies, broken sequences and noise
// are sent with random gaps while the report side stalls at random. A
// scoreboard predicts every report and compares each one field by field.
// ----------------------------------------------------------------------------
module tb_vt_report_response_parser;
    import vtrp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_BYTES = 1500;
    localparam int          IDLE_LIMIT   = 5000;
    localparam int          SETTLE_CYCLES = 6;
    localparam logic [31:0] VALUE_LIMIT  = (32'd1 << VALUE_BITS_DEF) - 32'd1;

    class report_scoreboard;
        phase_t                    phase;
        num_phase_t                num_phase;
        logic                      semi_seen;
        logic                      num_neg;
        logic                      lead_neg;
        logic [VALUE_BITS_DEF-1:0] lead_val;
        logic [VALUE_BITS_DEF-1:0] tail_val;
        report_t                   expected[$];
        int                        errors;

        function new();
            errors = 0;
            open_body(PH_IDLE);
        endfunction

        function void open_body(phase_t p);
            phase     = p;
            semi_seen = 1'b0;
            num_phase = NUM_SKIP;
            num_neg   = 1'b0;
            lead_neg  = 1'b0;
            lead_val  = '0;
            tail_val  = '0;
        endfunction

        // atoi-style step with saturation
        function void num_step(logic [7:0] b, inout logic [VALUE_BITS_DEF-1:0] acc);
            logic        is_digit;
            logic [31:0] m;
            is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
            case (num_phase)
                NUM_SKIP:
                begin
                    if (b == CH_SP || (b >= CH_TAB && b <= CH_CR))
                        return;
                    if (b == CH_PLUS)
                    begin
                        num_phase = NUM_DIGITS;
                        return;
                    end
                    if (b == CH_MINUS)
                    begin
                        num_neg   = 1'b1;
                        num_phase = NUM_DIGITS;
                        return;
                    end
                    if (!is_digit)
                    begin
                        num_phase = NUM_DONE;
                        return;
                    end
                    num_phase = NUM_DIGITS;
                end
                NUM_DIGITS:
                begin
                    if (!is_digit)
                    begin
                        num_phase = NUM_DONE;
                        return;
                    end
                end
                default:
                    return;
            endcase
            m = 32'(acc) * 32'd10 + 32'(b - CH_ZERO);
            acc = (m > VALUE_LIMIT) ? VALUE_LIMIT[VALUE_BITS_DEF-1:0] : m[VALUE_BITS_DEF-1:0];
        endfunction

        function void cursor_byte(logic [7:0] b);
            report_t rep;
            if (b == CH_CPR)
            begin
                if (semi_seen && !lead_neg && lead_val != 0 && !num_neg && tail_val != 0)
                begin
                    rep.kind = 1'b0;
                    rep.row  = ROW_W'(lead_val);
                    rep.col  = ROW_W'(tail_val);
                    rep.caps = '0;
                    expected.push_back(rep);
                end
                open_body(PH_IDLE);
            end
            else if (!semi_seen)
            begin
                if (b == CH_SEMI)
                begin
                    semi_seen = 1'b1;
                    lead_neg  = num_neg;
                    num_phase = NUM_SKIP;
                    num_neg   = 1'b0;
                end
                else
                    num_step(b, lead_val);
            end
            else
                num_step(b, tail_val);
        endfunction

        function void note_byte(logic [7:0] b);
            report_t           rep;
            logic [CAPS_W-1:0] mag;
            case (phase)
                PH_ESC:
                begin
                    if (b == CH_LB)
                        phase = PH_CSI;
                    else if (b != CH_ESC)
                        phase = PH_IDLE;
                end
                PH_CSI:
                begin
                    if (b == CH_Q)
                        open_body(PH_DA);
                    else
                    begin
                        open_body(PH_CPR);
                        cursor_byte(b);
                    end
                end
                PH_DA:
                begin
                    if (b == CH_DA)
                    begin
                        mag      = CAPS_W'(tail_val);
                        rep.kind = 1'b1;
                        rep.row  = '0;
                        rep.col  = '0;
                        rep.caps = semi_seen ? (num_neg ? -mag : mag) : '0;
                        expected.push_back(rep);
                        open_body(PH_IDLE);
                    end
                    else if (!semi_seen)
                    begin
                        if (b == CH_SEMI)
                        begin
                            semi_seen = 1'b1;
                            num_phase = NUM_SKIP;
                            num_neg   = 1'b0;
                        end
                    end
                    else
                        num_step(b, tail_val);
                end
                PH_CPR:
                    cursor_byte(b);
                default:
                    phase = (b == CH_ESC) ? PH_ESC : PH_IDLE;
            endcase
        endfunction

        function void check_report(logic kind, logic [M_TDATA_W-1:0] data);
            report_t exp;
            if (expected.size() == 0)
            begin
                $error("unexpected report: kind %0d, data %h", kind, data);
                errors++;
                return;
            end
            exp = expected.pop_front();
            if (kind !== exp.kind)
            begin
                $error("report_kind: expected %0d, got %0d", exp.kind, kind);
                errors++;
            end
            if (data[ROW_W-1:0] !== exp.row)
            begin
                $error("cursor_row: expected %0d, got %0d", exp.row, data[ROW_W-1:0]);
                errors++;
            end
            if (data[2*ROW_W-1:ROW_W] !== exp.col)
            begin
                $error("cursor_col: expected %0d, got %0d", exp.col, data[2*ROW_W-1:ROW_W]);
                errors++;
            end
            if (data[2*ROW_W+CAPS_W-1:2*ROW_W] !== exp.caps)
            begin
                $error("attr_caps: expected %0d, got %0d", exp.caps,
                       $signed(data[2*ROW_W+CAPS_W-1:2*ROW_W]));
                errors++;
            end
            if (data[M_TDATA_W-1:2*ROW_W+CAPS_W] !== '0)
            begin
                $error("tdata padding: expected 0, got %h", data[M_TDATA_W-1:2*ROW_W+CAPS_W]);
                errors++;
            end
        endfunction

        function void close();
            if (expected.size() != 0)
            begin
                $error("%0d reports never arrived", expected.size());
                errors += expected.size();
            end
        endfunction
    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // [15:0] row, [31:16] col, [48:32] caps, [55:49] zero
    logic [0:0]           m_tuser;   // [0] report_kind

    report_scoreboard sb = new();
    logic [7:0]       msg_bytes[$];
    int               sent_count  = 0;
    bit               send_steady = 1'b0;
    int               sink_stall  = 0;
    bit               sink_steady = 1'b0;
    int               sink_pick;
    int               idle_cycles = 0;

    vt_report_response_parser uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // report side: check, then choose next tready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_report(m_tuser[0], m_tdata);
        if ($urandom_range(0, 255) == 0)
            sink_steady = !sink_steady;
        if (sink_stall > 0)
        begin
            sink_stall--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!sink_steady)
            begin
                sink_pick = $urandom_range(0, 99);
                if (sink_pick < 25)
                    sink_stall = $urandom_range(1, 3);
                else if (sink_pick < 28)
                    sink_stall = $urandom_range(10, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_vt_report_response_parser: done, errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (send_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void push_digits(int n);
        repeat (n) msg_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    // optional whitespace and sign, then usually digits; sometimes long enough to saturate
    function automatic void push_number();
        int r;
        int k;
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 2))
            begin
                k = $urandom_range(0, 5);
                msg_bytes.push_back(k == 5 ? CH_SP : CH_TAB + 8'(k));
            end
        end
        r = $urandom_range(0, 9);
        if (r == 0)
            msg_bytes.push_back(CH_PLUS);
        else if (r == 1)
            msg_bytes.push_back(CH_MINUS);
        r = $urandom_range(0, 19);
        if (r == 1)
            push_digits($urandom_range(5, 7));
        else if (r != 0)
            push_digits($urandom_range(1, 3));
    endfunction

    function automatic void build_cursor();
        msg_bytes.push_back(CH_ESC);
        msg_bytes.push_back(CH_LB);
        push_number();
        if ($urandom_range(0, 9) != 0)
            msg_bytes.push_back(CH_SEMI);
        push_number();
        if ($urandom_range(0, 7) == 0)
            msg_bytes.push_back($urandom_range(0, 1) ? CH_SEMI : any_byte());
        msg_bytes.push_back(CH_CPR);
    endfunction

    function automatic void build_attr();
        msg_bytes.push_back(CH_ESC);
        msg_bytes.push_back(CH_LB);
        msg_bytes.push_back(CH_Q);
        if ($urandom_range(0, 1))
            push_digits($urandom_range(1, 2));
        if ($urandom_range(0, 6) != 0)
        begin
            msg_bytes.push_back(CH_SEMI);
            push_number();
            if ($urandom_range(0, 3) == 0)
            begin
                msg_bytes.push_back(CH_SEMI);
                push_digits($urandom_range(1, 2));
            end
        end
        msg_bytes.push_back(CH_DA);
    endfunction

    function automatic void build_broken();
        case ($urandom_range(0, 4))
            0:
            begin
                msg_bytes.push_back(CH_ESC);
                msg_bytes.push_back(any_byte());
            end
            1:
            begin
                repeat ($urandom_range(2, 3)) msg_bytes.push_back(CH_ESC);
                msg_bytes.push_back(CH_LB);
                msg_bytes.push_back(CH_CPR);
            end
            2:
            begin
                msg_bytes.push_back(CH_ESC);
                msg_bytes.push_back(CH_LB);
                repeat ($urandom_range(1, 4)) msg_bytes.push_back(any_byte());
                msg_bytes.push_back(CH_CPR);
            end
            3:
            begin
                msg_bytes.push_back(CH_ESC);
                msg_bytes.push_back(CH_LB);
                push_number();
                msg_bytes.push_back(CH_CPR);
            end
            default:
            begin
                msg_bytes.push_back(CH_ESC);
                msg_bytes.push_back(CH_LB);
                push_number();
                msg_bytes.push_back(CH_ESC);
                msg_bytes.push_back(CH_SEMI);
                push_number();
                msg_bytes.push_back(CH_CPR);
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_byte(b);
        sent_count++;
    endtask

    task automatic send_msg();
        send_steady = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i]);
        msg_bytes.delete();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        int r;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // byte extremes, repeated ESC, saturated row, signed column
        msg_bytes = '{8'h00, 8'hFF, CH_ESC, CH_ESC, CH_LB,
                      CH_ZERO + 8'd9, CH_ZERO + 8'd9, CH_ZERO + 8'd9, CH_ZERO + 8'd9,
                      CH_ZERO + 8'd9, CH_SEMI, CH_PLUS, CH_ZERO + 8'd7, CH_CPR};
        send_msg();
        // ESC inside body, negative caps, extra semicolon
        msg_bytes = '{CH_ESC, CH_LB, CH_Q, CH_ESC, CH_SEMI, CH_MINUS, CH_ZERO + 8'd5,
                      CH_SEMI, CH_DA};
        send_msg();
        // empty cursor body, attributes without semicolon
        msg_bytes = '{CH_ESC, CH_LB, CH_CPR, CH_ESC, CH_LB, CH_Q, CH_DA};
        send_msg();
        drain();

        while (sent_count < RANDOM_BYTES)
        begin
            r = $urandom_range(0, 99);
            if (r < 39)
                build_cursor();
            else if (r < 70)
                build_attr();
            else if (r < 85)
                build_broken();
            else
                repeat ($urandom_range(1, 4)) msg_bytes.push_back(any_byte());
            send_msg();
            if (sent_count >= RANDOM_BYTES / 2 && sent_count < RANDOM_BYTES / 2 + 20)
                drain();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.close();
        if (sb.errors == 0)
            $display("tb_vt_report_response_parser: done, clean");
        else
            $display("tb_vt_report_response_parser: done, errors");
        $finish;
    end

endmodule
